// ----- design/bvm_pkg.sv -----
// ----------------------------------------------------------------------------
// Battery voltage monitor package
// Shared widths, scale constants and the status word of the serial units.
// ----------------------------------------------------------------------------
package bvm_pkg;

   // Block size and field widths
   localparam int SAMPLES_PER_UPDATE = 8;
   localparam int SAMPLE_W           = 12;
   localparam int SUM_W              = 20;
   localparam int COUNT_W            = 9;
   localparam int MV_W               = 16;
   localparam int CHARGE_W           = 8;

   // Conversion constants: mv = avg * 33000 >> 12, charge = mv * 100 / (10 + span)
   localparam int ADC_BITS                   = 12;
   localparam logic [MV_W-1:0] MV_FULL_SCALE = 16'd33000;
   localparam logic [MV_W-1:0] CHARGE_OFFSET = 16'd10;
   localparam logic [MV_W-1:0] LOG_DELTA_RST = 16'd100;
   localparam logic [MV_W-1:0] MV_MAX        = 16'hFFFF;

   // Serial shift-add multiplier
   localparam int MUL_A_W   = 16;
   localparam int MUL_B_W   = 12;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam logic [MUL_B_W-1:0] CHARGE_SCALE = 12'd100;

   // Serial restoring divider
   localparam int DIV_N_W   = 22;
   localparam int DIV_D_W   = 16;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // Status word of a serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ----- design/bvm_mul.sv -----
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier that retires one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module bvm_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bvm_pkg::MUL_A_W-1:0]   mcand,
   input  logic [bvm_pkg::MUL_B_W-1:0]   mplier,
   output logic [bvm_pkg::MUL_P_W-1:0]   product,
   output bvm_pkg::unit_status_type      status
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bvm_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bvm_pkg::MUL_A_W-1:0]   mcand_ff, mcand_in;
   logic [bvm_pkg::MUL_B_W-1:0]   mplier_ff, mplier_in;
   logic [bvm_pkg::MUL_P_W-1:0]   prod_ff, prod_in;
   logic [bvm_pkg::MUL_A_W:0]     part_sum;

   // Add the multiplicand into the upper half when the current bit is set
   always_comb begin
      part_sum = {1'b0, prod_ff[bvm_pkg::MUL_P_W-1:bvm_pkg::MUL_B_W]}
               + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   // Load on start, then shift one bit per cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = mcand;
         mplier_in = mplier;
         prod_in   = '0;
      end else if (busy_ff) begin
         prod_in   = {part_sum, prod_ff[bvm_pkg::MUL_B_W-1:1]};
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == bvm_pkg::MUL_CNT_W'(bvm_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign product     = prod_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- design/bvm_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that produces one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module bvm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bvm_pkg::DIV_N_W-1:0]   dividend,
   input  logic [bvm_pkg::DIV_D_W-1:0]   divisor,
   output logic [bvm_pkg::DIV_N_W-1:0]   quotient,
   output bvm_pkg::unit_status_type      status
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bvm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [bvm_pkg::DIV_D_W-1:0]   dvsr_ff, dvsr_in;
   logic [bvm_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [bvm_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [bvm_pkg::DIV_D_W:0]     shifted;
   logic [bvm_pkg::DIV_D_W:0]     trial;
   logic                          fits;

   // Bring down the next dividend bit and try the subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[bvm_pkg::DIV_N_W-1]};
      trial   = shifted - {1'b0, dvsr_ff};
      fits    = (shifted >= {1'b0, dvsr_ff});
   end

   // Load on start, then one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvsr_in = dvsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvsr_in = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial[bvm_pkg::DIV_D_W-1:0] : shifted[bvm_pkg::DIV_D_W-1:0];
         quo_in = {quo_ff[bvm_pkg::DIV_N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bvm_pkg::DIV_CNT_W'(bvm_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- design/battery_voltage_monitor_top.sv -----
// ----------------------------------------------------------------------------
// Battery voltage monitor
// Block averaging of converter samples with min/max, charge figure and flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one 12-bit converter sample per word. Samples are
//   summed; every SAMPLES_PER_UPDATE-th sample closes a block and produces one
//   rsp_ word (voltage, charge figure, lowest, highest, change flag).
//   csr_wr_en / csr_wr_data set the change threshold in mV; write it idle.
//   A sample that does not close a block is only added to the sum. The
//   sample that closes a block is followed by a sequence of serial
//   arithmetic before rsp_valid rises: two passes of the 22-step divider
//   (average, charge) and two passes of the 12-step shift-add multiplier
//   (mV scaling, charge scaling). req_ready is low during that time.
//   A waiting rsp_ word does not block sampling; only the next block's
//   result waits until the held word is taken.
//   Reset: synchronous; clears the sum and count, sets lowest to 65535,
//   highest and last flagged voltage to 0, and the threshold to 100 mV.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module battery_voltage_monitor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bvm_pkg::SAMPLE_W-1:0]   req_adc_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bvm_pkg::MV_W-1:0]       rsp_voltage_mv,
   output logic [bvm_pkg::CHARGE_W-1:0]   rsp_charge_figure,
   output logic [bvm_pkg::MV_W-1:0]       rsp_lowest_mv,
   output logic [bvm_pkg::MV_W-1:0]       rsp_highest_mv,
   output logic                           rsp_change_flag,
   input  logic                           csr_wr_en,
   input  logic [bvm_pkg::MV_W-1:0]       csr_wr_data
);

   typedef enum logic [2:0] {
      ST_ACC,
      ST_AVG,
      ST_MV,
      ST_RANGE,
      ST_CMUL,
      ST_CDIV,
      ST_OUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [bvm_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [bvm_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [bvm_pkg::MV_W-1:0]        low_ff, low_in;
   logic [bvm_pkg::MV_W-1:0]        high_ff, high_in;
   logic [bvm_pkg::MV_W-1:0]        last_ff, last_in;
   logic [bvm_pkg::MV_W-1:0]        delta_ff, delta_in;
   logic [bvm_pkg::MV_W-1:0]        mv_ff, mv_in;
   logic [bvm_pkg::CHARGE_W-1:0]    charge_ff, charge_in;
   logic                            mul_start_ff, mul_start_in;
   logic [bvm_pkg::MUL_A_W-1:0]     mcand_ff, mcand_in;
   logic [bvm_pkg::MUL_B_W-1:0]     mplier_ff, mplier_in;
   logic                            div_start_ff, div_start_in;
   logic [bvm_pkg::DIV_N_W-1:0]     dividend_ff, dividend_in;
   logic [bvm_pkg::DIV_D_W-1:0]     divisor_ff, divisor_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bvm_pkg::MV_W-1:0]        o_mv_ff, o_mv_in;
   logic [bvm_pkg::CHARGE_W-1:0]    o_charge_ff, o_charge_in;
   logic [bvm_pkg::MV_W-1:0]        o_low_ff, o_low_in;
   logic [bvm_pkg::MV_W-1:0]        o_high_ff, o_high_in;
   logic                            o_flag_ff, o_flag_in;

   logic [bvm_pkg::MUL_P_W-1:0]     product;
   logic [bvm_pkg::DIV_N_W-1:0]     quotient;
   bvm_pkg::unit_status_type        mul_st;
   bvm_pkg::unit_status_type        div_st;

   logic [bvm_pkg::SUM_W-1:0]       sum_next;
   logic [bvm_pkg::COUNT_W-1:0]     count_next;
   logic [bvm_pkg::MV_W-1:0]        span;
   logic [bvm_pkg::MV_W-1:0]        diff;
   logic                            flag;
   logic                            accept;
   logic                            out_free;

   bvm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .mcand   (mcand_ff),
      .mplier  (mplier_ff),
      .product (product),
      .status  (mul_st)
   );

   bvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .quotient (quotient),
      .status   (div_st)
   );

   // Handshake and datapath helpers
   assign req_ready = (state_ff == ST_ACC);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sum_next   = sum_ff + {{(bvm_pkg::SUM_W - bvm_pkg::SAMPLE_W){1'b0}}, req_adc_sample};
      count_next = count_ff + 1'b1;
      span       = (high_ff >= low_ff) ? (high_ff - low_ff) : '0;
      diff       = (mv_ff >= last_ff) ? (mv_ff - last_ff) : (last_ff - mv_ff);
      flag       = (diff > delta_ff);
   end

   // Accumulate samples and sequence the block-end arithmetic through the shared serial units
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      last_in      = last_ff;
      delta_in     = csr_wr_en ? csr_wr_data : delta_ff;
      mv_in        = mv_ff;
      charge_in    = charge_ff;
      mul_start_in = 1'b0;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      div_start_in = 1'b0;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_mv_in      = o_mv_ff;
      o_charge_in  = o_charge_ff;
      o_low_in     = o_low_ff;
      o_high_in    = o_high_ff;
      o_flag_in    = o_flag_ff;

      case (state_ff)
         ST_ACC: begin
            if (accept) begin
               if (count_next == bvm_pkg::COUNT_W'(bvm_pkg::SAMPLES_PER_UPDATE)) begin
                  // Block complete: divide the sum by the block size
                  sum_in       = '0;
                  count_in     = '0;
                  dividend_in  = bvm_pkg::DIV_N_W'(sum_next);
                  divisor_in   = bvm_pkg::DIV_D_W'(bvm_pkg::SAMPLES_PER_UPDATE);
                  div_start_in = 1'b1;
                  state_in     = ST_AVG;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
               end
            end
         end
         ST_AVG: begin
            // Scale the average to millivolts
            if (div_st.done) begin
               mcand_in     = bvm_pkg::MV_FULL_SCALE;
               mplier_in    = quotient[bvm_pkg::MUL_B_W-1:0];
               mul_start_in = 1'b1;
               state_in     = ST_MV;
            end
         end
         ST_MV: begin
            if (mul_st.done) begin
               mv_in    = product[bvm_pkg::MUL_P_W-1:bvm_pkg::ADC_BITS];
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            // Track the extremes, then scale for the charge figure
            if (mv_ff > high_ff) begin
               high_in = mv_ff;
            end
            if (mv_ff < low_ff) begin
               low_in = mv_ff;
            end
            mcand_in     = mv_ff;
            mplier_in    = bvm_pkg::CHARGE_SCALE;
            mul_start_in = 1'b1;
            state_in     = ST_CMUL;
         end
         ST_CMUL: begin
            if (mul_st.done) begin
               dividend_in  = product[bvm_pkg::DIV_N_W-1:0];
               divisor_in   = span + bvm_pkg::CHARGE_OFFSET;
               div_start_in = 1'b1;
               state_in     = ST_CDIV;
            end
         end
         ST_CDIV: begin
            // Saturate the charge quotient
            if (div_st.done) begin
               charge_in = (|quotient[bvm_pkg::DIV_N_W-1:bvm_pkg::CHARGE_W]) ?
                           {bvm_pkg::CHARGE_W{1'b1}} : quotient[bvm_pkg::CHARGE_W-1:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_mv_in      = mv_ff;
               o_charge_in  = charge_ff;
               o_low_in     = low_ff;
               o_high_in    = high_ff;
               o_flag_in    = flag;
               if (flag) begin
                  last_in = mv_ff;
               end
               state_in = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         sum_ff       <= '0;
         count_ff     <= '0;
         low_ff       <= bvm_pkg::MV_MAX;
         high_ff      <= '0;
         last_ff      <= '0;
         delta_ff     <= bvm_pkg::LOG_DELTA_RST;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         last_ff      <= last_in;
         delta_ff     <= delta_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mv_ff       <= mv_in;
      charge_ff   <= charge_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      o_mv_ff     <= o_mv_in;
      o_charge_ff <= o_charge_in;
      o_low_ff    <= o_low_in;
      o_high_ff   <= o_high_in;
      o_flag_ff   <= o_flag_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voltage_mv    = o_mv_ff;
   assign rsp_charge_figure = o_charge_ff;
   assign rsp_lowest_mv     = o_low_ff;
   assign rsp_highest_mv    = o_high_ff;
   assign rsp_change_flag   = o_flag_ff;

   // The two serial units are never busy together
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_st.busy && div_st.busy))
      else $error("multiplier and divider busy at once");

   // The sample count never reaches the block size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < bvm_pkg::COUNT_W'(bvm_pkg::SAMPLES_PER_UPDATE))
      else $error("sample count reached block size");

   // A delivered word always has highest at or above lowest
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_highest_mv >= rsp_lowest_mv))
      else $error("highest below lowest in result word");

   // A flagged word leaves its voltage as the new reference
   a_flag_ref: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_change_flag) |-> (last_ff == rsp_voltage_mv))
      else $error("flag reference not updated");

endmodule
